// ===== rtl/ufmt_pkg.sv =====
// ufmt_pkg: shared types, constants and helpers of the unsigned decimal formatter
// used by every rtl file of the block but ufmt_checker; depends on nothing
`default_nettype none

package ufmt_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CountW  = 32;
  localparam int unsigned Digits  = 10;
  localparam int unsigned BcdW    = 4 * Digits;
  localparam int unsigned NdigW   = 4;
  localparam int unsigned WidthW  = 6;
  localparam int unsigned PrecW   = 7;
  localparam int unsigned IterW   = 5;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharSpace = 7'h20;

  localparam logic [WidthW-1:0] MinWidthRst  = '0;
  localparam logic [PrecW-1:0]  MinDigitsRst = 7'h7f;

  typedef enum logic [1:0] {
    REG_MIN_WIDTH    = 2'd0,
    REG_MIN_DIGITS   = 2'd1,
    REG_LEFT_JUSTIFY = 2'd2,
    REG_ZERO_PAD     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } front_state_e;

  typedef struct packed {
    logic [BcdW-1:0]  bcd;
    logic [NdigW-1:0] ndig;
  } ufmt_item_t;

  typedef struct packed {
    logic [WidthW-1:0] min_width;
    logic [PrecW-1:0]  min_digits;
    logic              left_justify;
    logic              zero_pad;
  } ufmt_cfg_t;

  function automatic logic [3:0] nibble_at(input logic [BcdW-1:0] bcd,
                                           input logic [NdigW-1:0] idx);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < Digits; i++) begin
      if (idx == NdigW'(i)) begin
        r = bcd[4*i +: 4];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ufmt_in_if.sv =====
// ufmt_in_if: input channel of the formatter, one binary value per word
// depends on ufmt_pkg
`default_nettype none

interface ufmt_in_if;
  import ufmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/ufmt_out_if.sv =====
// ufmt_out_if: output channel of the formatter, one ascii character per word
// depends on ufmt_pkg
`default_nettype none

interface ufmt_out_if;
  import ufmt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CharW-1:0]  out_char;
  logic              is_last;
  logic [CountW-1:0] emitted_count;

  modport source (output valid, output out_char, output is_last, output emitted_count,
                  input ready);
  modport sink   (input valid, input out_char, input is_last, input emitted_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ufmt_bcd_front.sv =====
// ufmt_bcd_front: accepts a value and converts it to bcd by shift-and-add-3
// depends on ufmt_pkg and ufmt_in_if
`default_nettype none

module ufmt_bcd_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  ufmt_in_if.sink                  in_i,
  output logic                     push_o,
  output ufmt_pkg::ufmt_item_t     item_o,
  input  wire                      full_i
);
  import ufmt_pkg::*;

  front_state_e      state_q, state_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic [ValueW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [BcdW-1:0]   adj;
  logic [NdigW-1:0]  ndig;
  logic              accept;

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: if (in_i.valid) state_d = FR_CONV;
      FR_CONV: if (iter_q == '1) state_d = FR_PUSH;
      FR_PUSH: if (!full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      FR_IDLE: in_i.ready = 1'b1;
      FR_CONV: ;
      FR_PUSH: push_o = !full_i;
      default: ;
    endcase
  end

  // shift-and-add-3 step
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    iter_d = iter_q;
    if (accept) begin
      bin_d  = in_i.value;
      bcd_d  = '0;
      iter_d = '0;
    end else if (state_q == FR_CONV) begin
      {bcd_d, bin_d} = {adj[BcdW-2:0], bin_q, 1'b0};
      iter_d         = iter_q + 1'b1;
    end
  end

  always_comb begin
    ndig = NdigW'(1);
    for (int i = 1; i < Digits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) ndig = NdigW'(i + 1);
    end
  end

  assign item_o.bcd  = bcd_q;
  assign item_o.ndig = ndig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire

// ===== rtl/ufmt_queue.sv =====
// ufmt_queue: two-entry queue of converted values between front and back
// depends on ufmt_pkg
`default_nettype none

module ufmt_queue (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      push_i,
  input  ufmt_pkg::ufmt_item_t     item_i,
  output logic                     full_o,
  input  wire                      pop_i,
  output logic                     avail_o,
  output ufmt_pkg::ufmt_item_t     item_o
);
  import ufmt_pkg::*;

  ufmt_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

`default_nettype wire

// ===== rtl/ufmt_emit_back.sv =====
// ufmt_emit_back: walks the head value's padded field, one character a cycle
// while the receiver is ready; depends on ufmt_pkg and ufmt_out_if
`default_nettype none

module ufmt_emit_back (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  ufmt_pkg::ufmt_cfg_t      cfg_i,
  input  wire                      avail_i,
  input  ufmt_pkg::ufmt_item_t     item_i,
  output logic                     pop_o,
  ufmt_out_if.source               out_o
);
  import ufmt_pkg::*;

  logic [WidthW-1:0] pos_q, pos_d;
  logic              valid_q;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic [CountW-1:0] count_q;

  logic              has_prec, load;
  logic [WidthW-1:0] prec, ndig, body, pad, total, q, lead0, didx;

  assign has_prec = !cfg_i.min_digits[PrecW-1];
  assign prec     = has_prec ? cfg_i.min_digits[WidthW-1:0] : '0;
  assign ndig     = WidthW'(item_i.ndig);
  assign body     = (ndig > prec) ? ndig : prec;
  assign lead0    = body - ndig;
  assign pad      = (cfg_i.min_width > body) ? cfg_i.min_width - body : '0;
  assign total    = (cfg_i.min_width > body) ? cfg_i.min_width : body;
  assign q        = cfg_i.left_justify ? pos_q : pos_q - pad;
  assign didx     = body - WidthW'(1) - q;

  always_comb begin
    if (!cfg_i.left_justify && pos_q < pad) begin
      char_d = (cfg_i.zero_pad && !has_prec) ? CharZero : CharSpace;
    end else if (q >= body) begin
      char_d = CharSpace;
    end else if (q < lead0) begin
      char_d = CharZero;
    end else begin
      char_d = CharZero + CharW'(nibble_at(item_i.bcd, didx[NdigW-1:0]));
    end
  end

  assign last_d = pos_q == total - WidthW'(1);
  assign load   = avail_i && (!valid_q || out_o.ready);
  assign pop_o  = load && last_d;
  assign pos_d  = last_d ? '0 : pos_q + WidthW'(1);

  assign out_o.valid         = valid_q;
  assign out_o.out_char      = char_q;
  assign out_o.is_last       = last_q;
  assign out_o.emitted_count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (load) begin
        pos_q   <= pos_d;
        count_q <= count_q + CountW'(1);
      end
      if (load) valid_q <= 1'b1;
      else if (out_o.ready) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/unsigned_decimal_formatter_top.sv =====
// unsigned_decimal_formatter_top: printf %u style decimal formatter
// depends on ufmt_pkg, ufmt_in_if, ufmt_out_if, ufmt_bcd_front, ufmt_queue,
// ufmt_emit_back
//
// in_i takes one 32-bit unsigned value per word; out_o gives its text, one
// ascii character per word, most significant first, is_last on the final one,
// emitted_count the running total of characters including this one
// the apb port writes min_width (0x0), min_digits (0x4, -1 = none),
// left_justify (0x8) and zero_pad (0xc); pready is tied high, reads return
// the register, writes are expected only while the block is idle
// a value is converted to bcd by one shift-add-3 step a cycle and then pushed
// into the queue when it has room; the front takes a new value only after the
// last one is pushed; the back loads the head value's characters into the
// output register, one per cycle while the receiver is ready; a value gives
// max(min_width, digits, precision) characters
// a two-entry queue decouples conversion from emission; a stalled receiver
// holds the output register and backs up the queue, then the input
// reset empties the queue, clears the running total and restores registers
`default_nettype none

module unsigned_decimal_formatter_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  ufmt_in_if.sink                      in_i,
  ufmt_out_if.source                   out_o,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [ufmt_pkg::AddrW-1:0]    paddr,
  input  wire [ufmt_pkg::DataW-1:0]    pwdata,
  output logic [ufmt_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import ufmt_pkg::*;

  ufmt_cfg_t  cfg_q;
  reg_idx_e   reg_idx;
  logic       wr_en;
  logic       push, full, pop, avail;
  ufmt_item_t front_item, head_item;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      REG_MIN_WIDTH:    prdata = DataW'(cfg_q.min_width);
      REG_MIN_DIGITS:   prdata = DataW'(cfg_q.min_digits);
      REG_LEFT_JUSTIFY: prdata = DataW'(cfg_q.left_justify);
      REG_ZERO_PAD:     prdata = DataW'(cfg_q.zero_pad);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width    <= MinWidthRst;
      cfg_q.min_digits   <= MinDigitsRst;
      cfg_q.left_justify <= 1'b0;
      cfg_q.zero_pad     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_WIDTH:    cfg_q.min_width    <= pwdata[WidthW-1:0];
        REG_MIN_DIGITS:   cfg_q.min_digits   <= pwdata[PrecW-1:0];
        REG_LEFT_JUSTIFY: cfg_q.left_justify <= pwdata[0];
        REG_ZERO_PAD:     cfg_q.zero_pad     <= pwdata[0];
        default:          ;
      endcase
    end
  end

  ufmt_bcd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .item_o (front_item),
    .full_i (full)
  );

  ufmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (head_item)
  );

  ufmt_emit_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .avail_i (avail),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ufmt_checker.sv =====
// ufmt_checker: port-level assertions of the formatter, bound to the top level
// depends on unsigned_decimal_formatter_top and its interfaces
`default_nettype none

module ufmt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [6:0]  out_char,
  input wire        out_last,
  input wire [31:0] out_count
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last)
                                && $stable(out_count))
    else $error("stalled output word changed");

  // the front is busy converting right after it takes a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during conversion");

  // back-to-back words count up by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready ##1 out_valid |-> out_count == $past(out_count) + 32'd1)
    else $error("running total skipped");

  // every character is a digit or a space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_char == 7'h20) || ((out_char >= 7'h30) && (out_char <= 7'h39)))
    else $error("character out of range");

endmodule

bind unsigned_decimal_formatter_top ufmt_checker u_ufmt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_char  (out_o.out_char),
  .out_last  (out_o.is_last),
  .out_count (out_o.emitted_count)
);

`default_nettype wire

// ===== sim/unsigned_decimal_formatter_top_tb.sv =====
// unsigned_decimal_formatter_top_tb: drives values and apb register writes into the
// formatter and checks every character word against a %u formatting predictor
// depends on ufmt_pkg, ufmt_in_if, ufmt_out_if and unsigned_decimal_formatter_top
`timescale 1ns / 1ps

module unsigned_decimal_formatter_top_tb;
  import ufmt_pkg::*;

  typedef struct {
    logic [CharW-1:0]  ch;
    logic              last;
    logic [CountW-1:0] count;
  } char_word_t;

  class decimal_scoreboard;
    ufmt_cfg_t         cfg;
    logic [CountW-1:0] char_total;
    char_word_t        pending_chars[$];
    int unsigned       errors;

    function new();
      cfg.min_width    = MinWidthRst;
      cfg.min_digits   = MinDigitsRst;
      cfg.left_justify = 1'b0;
      cfg.zero_pad     = 1'b0;
      char_total       = '0;
      errors           = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] data);
      case (idx)
        REG_MIN_WIDTH:    cfg.min_width    = data[WidthW-1:0];
        REG_MIN_DIGITS:   cfg.min_digits   = data[PrecW-1:0];
        REG_LEFT_JUSTIFY: cfg.left_justify = data[0];
        REG_ZERO_PAD:     cfg.zero_pad     = data[0];
        default: ;
      endcase
    endfunction

    function void push_char(logic [CharW-1:0] ch);
      char_word_t w;
      char_total = char_total + 1;
      w.ch    = ch;
      w.last  = 1'b0;
      w.count = char_total;
      pending_chars.push_back(w);
    endfunction

    function void push_run(logic [CharW-1:0] ch, int unsigned n);
      for (int unsigned i = 0; i < n; i++) push_char(ch);
    endfunction

    // expected text of one value under the current registers
    function void format_value(logic [ValueW-1:0] v);
      logic [3:0]        digs[Digits];
      logic [ValueW-1:0] rest;
      int unsigned       nd;
      bit                has_prec;
      int unsigned       prec;
      int unsigned       body;
      int unsigned       pad;
      nd   = 0;
      rest = v;
      do begin
        digs[nd] = 4'(rest % 10);
        rest     = rest / 10;
        nd++;
      end while (rest != 0 && nd < Digits);
      has_prec = !cfg.min_digits[PrecW-1];
      prec     = has_prec ? int'(cfg.min_digits) : 0;
      body     = (nd > prec) ? nd : prec;
      pad      = (cfg.min_width > body) ? int'(cfg.min_width) - body : 0;
      if (!cfg.left_justify) begin
        push_run((cfg.zero_pad && !has_prec) ? CharZero : CharSpace, pad);
      end
      push_run(CharZero, body - nd);
      for (int i = int'(nd) - 1; i >= 0; i--) push_char(CharZero + CharW'(digs[i]));
      if (cfg.left_justify) begin
        push_run(CharSpace, pad);
      end
      pending_chars[pending_chars.size()-1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_char(logic [CharW-1:0] ch, logic last, logic [CountW-1:0] count);
      char_word_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("char %h with no word expected", ch));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch) report($sformatf("out_char %h, want %h", ch, want.ch));
      if (last !== want.last) report($sformatf("is_last %b, want %b", last, want.last));
      if (count !== want.count) begin
        report($sformatf("emitted_count %0d, want %0d", count, want.count));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  ufmt_in_if  in_if ();
  ufmt_out_if out_if ();

  decimal_scoreboard sb = new();

  bit          calm;
  int unsigned stall_odds;

  unsigned_decimal_formatter_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("unsigned_decimal_formatter_top_tb failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.format_value(in_if.value);
      if (out_if.valid && out_if.ready) begin
        sb.check_char(out_if.out_char, out_if.is_last, out_if.emitted_count);
      end
    end
  end

  // receiver stalls
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, stall_odds) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx) << 2;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_value(logic [ValueW-1:0] v);
    in_if.valid <= 1'b1;
    in_if.value <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic pick_setting();
    logic [DataW-1:0] fw;
    logic [DataW-1:0] md;
    case ($urandom_range(0, 7))
      0:       fw = 0;
      1:       fw = 63;
      2:       fw = $urandom_range(0, 63);
      default: fw = $urandom_range(0, 12);
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: md = 32'hffff_ffff;
      3:       md = -DataW'($urandom_range(2, 64));
      4:       md = 63;
      5:       md = 0;
      default: md = $urandom_range(1, 12);
    endcase
    write_reg(REG_MIN_WIDTH, ($urandom & ~32'h3f) | fw);
    write_reg(REG_MIN_DIGITS, md);
    write_reg(REG_LEFT_JUSTIFY, ($urandom & ~32'h1) | ($urandom_range(0, 2) == 0));
    write_reg(REG_ZERO_PAD, ($urandom & ~32'h1) | $urandom_range(0, 1));
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    logic [ValueW-1:0] p;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      3: return $urandom_range(0, 1) ? '0 : '1;
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  initial begin
    calm        = 1'b0;
    stall_odds  = 7;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: plain digits
    send_value(0);
    send_value(1);
    send_value(9);
    send_value(10);
    send_value(999_999_999);
    send_value(1_000_000_000);
    send_value(32'hffff_ffff);
    send_value(32'h8000_0000);
    send_value(32'h5555_5555);
    send_value(32'haaaa_aaaa);
    wait_idle();

    // widest field, zero padded
    write_reg(REG_MIN_WIDTH, 63);
    write_reg(REG_ZERO_PAD, 1);
    send_value(0);
    send_value(32'hffff_ffff);
    wait_idle();

    // zero with precision zero still prints a digit
    write_reg(REG_MIN_DIGITS, 0);
    write_reg(REG_ZERO_PAD, 0);
    write_reg(REG_MIN_WIDTH, 5);
    send_value(0);
    send_value(7);
    wait_idle();

    // largest precision
    write_reg(REG_MIN_DIGITS, 63);
    write_reg(REG_MIN_WIDTH, 0);
    send_value(12345);
    wait_idle();

    // negative precision other than -1 counts as none
    write_reg(REG_MIN_DIGITS, 32'h40);
    write_reg(REG_ZERO_PAD, 1);
    write_reg(REG_MIN_WIDTH, 15);
    send_value(321);
    wait_idle();

    // left justified, with precision, then without, then with zero pad set
    write_reg(REG_LEFT_JUSTIFY, 1);
    write_reg(REG_MIN_DIGITS, 5);
    write_reg(REG_MIN_WIDTH, 12);
    write_reg(REG_ZERO_PAD, 0);
    send_value(42);
    wait_idle();
    write_reg(REG_MIN_DIGITS, 32'hffff_ffff);
    send_value(0);
    wait_idle();
    write_reg(REG_ZERO_PAD, 1);
    send_value(77);
    wait_idle();

    for (int ph = 0; ph < 20; ph++) begin
      case ($urandom_range(0, 3))
        0:       stall_odds = 2;
        1:       stall_odds = 1000;
        default: stall_odds = 7;
      endcase
      if (ph >= 18) calm = 1'b1;
      pick_setting();
      repeat (25) send_value(rand_value());
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("unsigned_decimal_formatter_top_tb passed");
    end else begin
      $display("unsigned_decimal_formatter_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ufmt_pkg.sv
rtl/ufmt_in_if.sv
rtl/ufmt_out_if.sv
rtl/ufmt_bcd_front.sv
rtl/ufmt_queue.sv
rtl/ufmt_emit_back.sv
rtl/unsigned_decimal_formatter_top.sv
rtl/ufmt_checker.sv
sim/unsigned_decimal_formatter_top_tb.sv
